>>> rtl/jet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_pkg
// shared types, constants and helpers for the julia escape-time block
// ----------------------------------------------------------------------------
package jet_pkg;

  // number format and picture limits
  localparam int FRAC_BITS = 28;
  localparam int MAX_RES   = 4096;
  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit HAS_THR   = (ESC_SHIFT < 64);

  // configuration register indexes
  localparam logic [2:0] REG_X_MIN    = 3'd0;
  localparam logic [2:0] REG_Y_MAX    = 3'd1;
  localparam logic [2:0] REG_STEP_X   = 3'd2;
  localparam logic [2:0] REG_STEP_Y   = 3'd3;
  localparam logic [2:0] REG_C_IMAG   = 3'd4;
  localparam logic [2:0] REG_MAX_ITER = 3'd5;

  // register reset values
  localparam logic signed [31:0] X_MIN_RST    = -32'sd536870912;
  localparam logic signed [31:0] Y_MAX_RST    = 32'sd536870912;
  localparam logic [30:0]        STEP_X_RST   = 31'd536871;
  localparam logic [30:0]        STEP_Y_RST   = 31'd536871;
  localparam logic signed [31:0] C_IMAG_RST   = -32'sd526133494;
  localparam logic [15:0]        MAX_ITER_RST = 16'd500;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_MUL,
    S_TEST,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture pixel indexes
    logic map;    // compute starting point, counter to one
    logic mul;    // register the three products
    logic upd;    // take one julia step
    logic emit;   // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;   // limit reached or point escaped
  } status_t;

  // saturate a signed 64-bit value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    logic same;
    same = (a[63:31] == {33{1'b0}}) || (a[63:31] == {33{1'b1}});
    if (same) begin
      return a[31:0];
    end else if (a[63]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

endpackage

>>> rtl/jet_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_ctrl
// sequencer for one pixel at a time and the result valid flag
// ----------------------------------------------------------------------------
module jet_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  jet_pkg::status_t   sts,
  output jet_pkg::cmd_t      cmd
);

  jet_pkg::state_t state;
  jet_pkg::state_t state_next;
  logic            out_valid_next;
  logic            slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jet_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      jet_pkg::S_IDLE: begin
        if (in_valid) state_next = jet_pkg::S_MAP;
      end
      jet_pkg::S_MAP:  state_next = jet_pkg::S_MUL;
      jet_pkg::S_MUL:  state_next = jet_pkg::S_TEST;
      jet_pkg::S_TEST: begin
        state_next = sts.done ? jet_pkg::S_DONE : jet_pkg::S_MUL;
      end
      jet_pkg::S_DONE: begin
        if (slot_free) state_next = jet_pkg::S_IDLE;
      end
      default: state_next = jet_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      jet_pkg::S_IDLE: begin
        // no transaction taken while reset is held
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      jet_pkg::S_MAP:  cmd.map = 1'b1;
      jet_pkg::S_MUL:  cmd.mul = 1'b1;
      jet_pkg::S_TEST: cmd.upd = !sts.done;
      jet_pkg::S_DONE: begin
        if (slot_free) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_emit_free : assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting transaction");

  a_accept_map : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == jet_pkg::S_MAP))
    else $error("accepted transaction not mapped");

  a_done_exit : assert property (@(posedge clk) disable iff (rst)
    (state == jet_pkg::S_TEST && sts.done) |=> (state == jet_pkg::S_DONE))
    else $error("finished pixel kept iterating");

  a_valid_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result valid without a finished pixel");

endmodule

>>> rtl/jet_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_dpath
// configuration registers, point mapping, julia iteration and result register
// ----------------------------------------------------------------------------
module jet_dpath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [31:0]         cfg_wdata,
  input  logic [11:0]         col,
  input  logic [11:0]         row,
  input  jet_pkg::cmd_t       cmd,
  output jet_pkg::status_t    sts,
  output logic [15:0]         iter_count,
  output logic                interior
);

  localparam int F = jet_pkg::FRAC_BITS;

  logic signed [31:0] x_min;
  logic signed [31:0] y_max;
  logic [30:0]        step_x;
  logic [30:0]        step_y;
  logic signed [31:0] c_imag;
  logic [15:0]        max_iter;

  logic [11:0]        col_q;
  logic [11:0]        row_q;
  logic [11:0]        col_c;
  logic [11:0]        row_c;
  logic signed [31:0] u;
  logic signed [31:0] v;
  logic signed [63:0] p_uu;
  logic signed [63:0] p_vv;
  logic signed [63:0] p_uv;
  logic [15:0]        k;

  logic [42:0]        prod_x;
  logic [42:0]        prod_y;
  logic signed [63:0] x_full;
  logic signed [63:0] y_full;
  logic [63:0]        mag;
  logic               esc;
  logic               at_limit;
  logic signed [63:0] d_uv;
  logic signed [63:0] nu_full;
  logic signed [63:0] nv_full;

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min    <= jet_pkg::X_MIN_RST;
      y_max    <= jet_pkg::Y_MAX_RST;
      step_x   <= jet_pkg::STEP_X_RST;
      step_y   <= jet_pkg::STEP_Y_RST;
      c_imag   <= jet_pkg::C_IMAG_RST;
      max_iter <= jet_pkg::MAX_ITER_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        jet_pkg::REG_X_MIN:    x_min    <= cfg_wdata;
        jet_pkg::REG_Y_MAX:    y_max    <= cfg_wdata;
        jet_pkg::REG_STEP_X:   step_x   <= cfg_wdata[30:0];
        jet_pkg::REG_STEP_Y:   step_y   <= cfg_wdata[30:0];
        jet_pkg::REG_C_IMAG:   c_imag   <= cfg_wdata;
        jet_pkg::REG_MAX_ITER: max_iter <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // index clamp
  assign col_c = (32'(col) >= 32'(jet_pkg::MAX_RES)) ? 12'(jet_pkg::MAX_RES - 1) : col;
  assign row_c = (32'(row) >= 32'(jet_pkg::MAX_RES)) ? 12'(jet_pkg::MAX_RES - 1) : row;

  // window mapping
  assign prod_x = 43'(col_q) * 43'(step_x);
  assign prod_y = 43'(row_q) * 43'(step_y);
  assign x_full = 64'(x_min) + $signed({21'd0, prod_x});
  assign y_full = 64'(y_max) - $signed({21'd0, prod_y});

  // escape test and next point
  assign mag      = 64'(p_uu) + 64'(p_vv);
  assign esc      = jet_pkg::HAS_THR && ((mag >> jet_pkg::ESC_SHIFT) != 64'd0);
  assign at_limit = !(k < max_iter);
  assign sts.done = at_limit || esc;
  assign d_uv     = p_uu - p_vv;
  assign nu_full  = d_uv >>> F;
  assign nv_full  = (p_uv >>> (F - 1)) + 64'(c_imag);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_q <= col_c;
      row_q <= row_c;
    end
    if (cmd.map) begin
      u <= jet_pkg::sat32(x_full);
      v <= jet_pkg::sat32(y_full);
      k <= 16'd1;
    end
    if (cmd.mul) begin
      p_uu <= u * u;
      p_vv <= v * v;
      p_uv <= u * v;
    end
    if (cmd.upd) begin
      u <= jet_pkg::sat32(nu_full);
      v <= jet_pkg::sat32(nv_full);
      k <= k + 16'd1;
    end
    if (cmd.emit) begin
      iter_count <= k;
      interior   <= !(k < max_iter);
    end
  end

endmodule

>>> rtl/julia_escape_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time
// escape-time count of the julia map z = z*z + i*c for one pixel
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid, in_stall, col, row): one transaction is one pixel
// - output channel (out_valid, out_stall, iter_count, interior): one result
//   transaction per pixel, in pixel order
// - config port (cfg_we, cfg_idx, cfg_wdata): write registers while idle,
//   index 0 x_min, 1 y_max, 2 step_x, 3 step_y, 4 c_imag, 5 max_iter
// - one pixel is worked at a time: accept, a mapping step, then per
//   iteration the products into registers, then escape test and update
// - the result is loaded from the final state; the next pixel can be
//   taken while that result is shown, so the time per pixel grows with
//   iter_count, up to the default limit of 500
// - the time per pixel is set by the multiply / update loop over u and v
// - a finished result waits in an output register; a stalled receiver only
//   holds the next pixel in its final state once that register is full
// - reset restores the default window and constant and drops any transaction
// ----------------------------------------------------------------------------
module julia_escape_time (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] col,
  input  logic [11:0] row,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] iter_count,
  output logic        interior
);

  jet_pkg::cmd_t    cmd;
  jet_pkg::status_t sts;

  // sequencer
  jet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and registers
  jet_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .col        (col),
    .row        (row),
    .cmd        (cmd),
    .sts        (sts),
    .iter_count (iter_count),
    .interior   (interior)
  );

endmodule
